[sv/marq_pkg.sv]
// Shared types and codes for the MAC acknowledgement retry queue.
// Holds the input word, result word and table entry layouts.
// No dependencies; every other file of the block but marq_stream_if uses this package.
package marq_pkg;

  localparam int SeqW = 8;
  localparam int HandleW = 8;
  localparam int BufferW = 8;
  localparam int RetryW = 3;
  localparam int ExpiryW = 8;
  localparam int KindW = 3;
  localparam int ActionW = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 8;

  // Input kinds.
  localparam logic [KindW-1:0] KIND_ADD    = 3'd0;
  localparam logic [KindW-1:0] KIND_ACK    = 3'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KindW-1:0] KIND_TICK   = 3'd3;
  localparam logic [KindW-1:0] KIND_CLEAR  = 3'd4;

  // Result actions.
  localparam logic [ActionW-1:0] ACT_NONE     = 3'd0;
  localparam logic [ActionW-1:0] ACT_SUCCESS  = 3'd1;
  localparam logic [ActionW-1:0] ACT_NOACK    = 3'd2;
  localparam logic [ActionW-1:0] ACT_RETX     = 3'd3;
  localparam logic [ActionW-1:0] ACT_RELEASED = 3'd4;
  localparam logic [ActionW-1:0] ACT_DROPPED  = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_WAIT_TICKS = 1'd1;

  localparam logic [RetryW-1:0]  MaxRetriesReset = 3'd3;
  localparam logic [ExpiryW-1:0] AckWaitReset    = 8'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [SeqW-1:0]    seq_number;
    logic [HandleW-1:0] frame_handle;
    logic [BufferW-1:0] buffer_id;
  } in_item_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [HandleW-1:0] out_handle;
    logic [SeqW-1:0]    out_seq;
    logic [BufferW-1:0] out_buffer;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [SeqW-1:0]    seq;
    logic [HandleW-1:0] handle;
    logic [BufferW-1:0] buffer;
    logic [RetryW-1:0]  retries;
    logic [ExpiryW-1:0] expiry;
  } entry_t;

endpackage

[sv/marq_stream_if.sv]
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; depends on nothing else.
interface marq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/marq_table.sv]
// Entry table of the retry queue: one write port, one registered read port.
// Depends on marq_pkg for the entry layout.
module marq_table #(
  parameter int ENTRIES = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  marq_pkg::entry_t           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output marq_pkg::entry_t           rd_data
);

  marq_pkg::entry_t mem [ENTRIES];
  marq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/marq_ctrl.sv]
// Sequencer of the retry queue: walks the table, compacts it and builds results.
// Depends on marq_pkg; drives the marq_table ports.
module marq_ctrl #(
  parameter int ENTRIES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  marq_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output marq_pkg::out_item_t             out_data,
  input  logic [marq_pkg::RetryW-1:0]     max_retries,
  input  logic [marq_pkg::ExpiryW-1:0]    ack_wait_ticks,
  output logic                            tbl_wr_en,
  output logic [$clog2(ENTRIES)-1:0]      tbl_wr_addr,
  output marq_pkg::entry_t                tbl_wr_data,
  output logic                            tbl_rd_en,
  output logic [$clog2(ENTRIES)-1:0]      tbl_rd_addr,
  input  marq_pkg::entry_t                tbl_rd_data
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [marq_pkg::KindW-1:0]     op_r, op_nxt;
  logic [marq_pkg::SeqW-1:0]      key_r, key_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  wr_r, wr_nxt;
  logic                           found_r, found_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  marq_pkg::out_item_t            pend_r, pend_nxt;
  logic                           out_valid_r, out_valid_nxt;
  marq_pkg::out_item_t            out_r, out_nxt;

  logic                           out_free;
  logic                           is_clear;
  logic [CW-1:0]                  idx_inc;
  logic [CW-1:0]                  rd_pos;
  logic                           res_valid;
  logic [marq_pkg::ActionW-1:0]   res_action;
  logic                           keep;
  marq_pkg::entry_t               ent;
  marq_pkg::entry_t               new_ent;
  logic [marq_pkg::RetryW-1:0]    ret_dec;
  logic                           stall;

  assign out_free = !out_valid_r || out_ready;
  assign is_clear = (op_r == marq_pkg::KIND_CLEAR);
  assign idx_inc  = idx_r + CW'(1);
  assign ent      = tbl_rd_data;
  assign ret_dec  = (ent.retries != '0) ? ent.retries - marq_pkg::RetryW'(1) : '0;

  // Per-entry decision of the walk.
  always_comb begin
    res_valid  = 1'b0;
    res_action = marq_pkg::ACT_NONE;
    keep       = 1'b1;
    new_ent    = ent;
    case (op_r)
      marq_pkg::KIND_TICK: begin
        if (ent.expiry == '0) begin
          new_ent.retries = ret_dec;
          res_valid       = 1'b1;
          if (ret_dec != '0) begin
            new_ent.expiry = ack_wait_ticks;
            res_action     = marq_pkg::ACT_RETX;
          end else begin
            keep       = 1'b0;
            res_action = marq_pkg::ACT_NOACK;
          end
        end else begin
          new_ent.expiry = ent.expiry - marq_pkg::ExpiryW'(1);
        end
      end
      marq_pkg::KIND_ACK, marq_pkg::KIND_REMOVE: begin
        if (!found_r && ent.seq == key_r) begin
          res_valid  = 1'b1;
          keep       = 1'b0;
          res_action = (op_r == marq_pkg::KIND_ACK) ? marq_pkg::ACT_SUCCESS
                                                    : marq_pkg::ACT_RELEASED;
        end
      end
      marq_pkg::KIND_CLEAR: begin
        res_valid  = 1'b1;
        keep       = 1'b0;
        res_action = marq_pkg::ACT_RELEASED;
      end
      default: begin
        keep = 1'b1;
      end
    endcase
  end

  // A result waits for the pending slot to drain into the output register.
  assign stall = res_valid && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    tbl_wr_en      = 1'b0;
    tbl_wr_addr    = wr_r[AW-1:0];
    tbl_wr_data    = new_ent;
    tbl_rd_en      = 1'b0;
    rd_pos         = '0;
    tbl_rd_addr    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.kind;
          key_nxt   = in_data.seq_number;
          idx_nxt   = '0;
          wr_nxt    = '0;
          found_nxt = 1'b0;
          case (in_data.kind)
            marq_pkg::KIND_ADD: begin
              if (cnt_r < CW'(ENTRIES)) begin
                tbl_wr_en           = 1'b1;
                tbl_wr_addr         = cnt_r[AW-1:0];
                tbl_wr_data.seq     = in_data.seq_number;
                tbl_wr_data.handle  = in_data.frame_handle;
                tbl_wr_data.buffer  = in_data.buffer_id;
                tbl_wr_data.retries = max_retries;
                tbl_wr_data.expiry  = ack_wait_ticks;
                cnt_nxt             = cnt_r + CW'(1);
              end else begin
                pend_valid_nxt      = 1'b1;
                pend_nxt.action     = marq_pkg::ACT_DROPPED;
                pend_nxt.out_handle = in_data.frame_handle;
                pend_nxt.out_seq    = in_data.seq_number;
                pend_nxt.out_buffer = in_data.buffer_id;
                pend_nxt.last       = 1'b0;
                state_nxt           = ST_DONE;
              end
            end
            marq_pkg::KIND_ACK, marq_pkg::KIND_REMOVE, marq_pkg::KIND_TICK,
            marq_pkg::KIND_CLEAR: begin
              if (cnt_r != '0) begin
                // Clear walks newest first; the other kinds oldest first.
                tbl_rd_en   = 1'b1;
                rd_pos      = (in_data.kind == marq_pkg::KIND_CLEAR) ?
                              cnt_r - CW'(1) : '0;
                tbl_rd_addr = rd_pos[AW-1:0];
                state_nxt   = ST_WALK;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (!stall) begin
          // Kept entries are written back at the compaction pointer, which
          // never passes the read pointer, so no read sees a stale entry.
          if (keep) begin
            tbl_wr_en = 1'b1;
            wr_nxt    = wr_r + CW'(1);
          end
          if (res_valid) begin
            if (op_r != marq_pkg::KIND_TICK) begin
              found_nxt = 1'b1;
            end
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_nxt.last  = 1'b0;
            end
            pend_valid_nxt      = 1'b1;
            pend_nxt.action     = res_action;
            pend_nxt.out_handle = ent.handle;
            pend_nxt.out_seq    = ent.seq;
            pend_nxt.out_buffer = ent.buffer;
            pend_nxt.last       = 1'b0;
          end
          idx_nxt = idx_inc;
          if (idx_inc < cnt_r) begin
            tbl_rd_en   = 1'b1;
            rd_pos      = is_clear ? cnt_r - CW'(1) - idx_inc : idx_inc;
            tbl_rd_addr = rd_pos[AW-1:0];
          end else begin
            cnt_nxt   = keep ? wr_r + CW'(1) : wr_r;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_nxt.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    wr_r   <= wr_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sv/mac_ack_retry_queue_core.sv]
// Top level of the MAC acknowledgement retry queue.
// Depends on marq_pkg, marq_stream_if, marq_table and marq_ctrl.
//
// Usage:
// The input channel (in_if) carries one command word: add, ack received,
// remove, tick or clear all. The result channel (out_if) returns zero or
// more result words per command; the final one has last set. Both channels
// use valid/ready and move a word at an edge where both are high.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the retry
// budget (index 0) and the ack wait in ticks (index 1); write it only while
// the block is idle.
// Operation: an add that fits in the table gives no result.
// Ack, remove, tick and clear stream the table through the single read port
// of the entry memory, one entry per cycle unless results back up; a
// full-table add gives a dropped result. A new command is taken once the
// previous one has finished its walk and passed its final result on.
// Results pass through a pending slot and an output register, so the walk
// keeps going while one result waits; if the receiver stalls with both
// holding a word, the walk pauses on the current entry until space frees.
// Reset empties the table and loads the register defaults (3 and 2); the
// memory contents are not cleared, since only entries below the count are
// ever read.
module mac_ack_retry_queue_core #(
  parameter int ENTRIES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  marq_stream_if.sink                       in_if,
  marq_stream_if.source                     out_if,
  input  logic                              cfg_we,
  input  logic [marq_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [marq_pkg::CfgDataW-1:0]     cfg_wdata
);

  localparam int AW = $clog2(ENTRIES);

  logic [marq_pkg::RetryW-1:0]  max_retries_r;
  logic [marq_pkg::ExpiryW-1:0] ack_wait_r;

  logic                 tbl_wr_en;
  logic [AW-1:0]        tbl_wr_addr;
  marq_pkg::entry_t     tbl_wr_data;
  logic                 tbl_rd_en;
  logic [AW-1:0]        tbl_rd_addr;
  marq_pkg::entry_t     tbl_rd_data;
  marq_pkg::in_item_t   in_word;
  marq_pkg::out_item_t  out_word;

  // Configuration registers; only the low bits of the data are kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= marq_pkg::MaxRetriesReset;
      ack_wait_r    <= marq_pkg::AckWaitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        marq_pkg::CFG_MAX_RETRIES: begin
          max_retries_r <= cfg_wdata[marq_pkg::RetryW-1:0];
        end
        marq_pkg::CFG_ACK_WAIT_TICKS: begin
          ack_wait_r <= cfg_wdata[marq_pkg::ExpiryW-1:0];
        end
        default: begin
          ack_wait_r <= ack_wait_r;
        end
      endcase
    end
  end

  assign in_word     = in_if.data;
  assign out_if.data = out_word;

  marq_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  marq_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_data        (in_word),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_data       (out_word),
    .max_retries    (max_retries_r),
    .ack_wait_ticks (ack_wait_r),
    .tbl_wr_en      (tbl_wr_en),
    .tbl_wr_addr    (tbl_wr_addr),
    .tbl_wr_data    (tbl_wr_data),
    .tbl_rd_en      (tbl_rd_en),
    .tbl_rd_addr    (tbl_rd_addr),
    .tbl_rd_data    (tbl_rd_data)
  );

endmodule

[test/mac_ack_retry_queue_core_test.sv]
// Self-checking testbench for mac_ack_retry_queue_core: random and directed command words
// are checked against a behavioral model of the retry table kept inside this module.
// Depends on marq_pkg, marq_stream_if and the block's RTL.
`timescale 1ns / 1ps

module mac_ack_retry_queue_core_test;

  localparam int TableDepth = 8;
  // Longest walk of an ack, remove, tick or clear that yields no word, plus margin.
  localparam int SettleCycles = TableDepth + 8;
  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int WatchdogLimit = 2000;
  localparam logic [marq_pkg::KindW-1:0] KIND_SPARE_LO = marq_pkg::KIND_CLEAR + 3'd1;
  localparam logic [marq_pkg::KindW-1:0] KIND_SPARE_HI = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [marq_pkg::CfgIdxW-1:0] cfg_index;
  logic [marq_pkg::CfgDataW-1:0] cfg_wdata;

  marq_stream_if #(.T(marq_pkg::in_item_t)) cmd_ch ();
  marq_stream_if #(.T(marq_pkg::out_item_t)) rpt_ch ();

  mac_ack_retry_queue_core #(.ENTRIES(TableDepth)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(cmd_ch),
    .out_if(rpt_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Command words waiting to be offered, and the result words the model expects
  // from the block, oldest first.
  marq_pkg::in_item_t pending_commands[$];
  marq_pkg::out_item_t expected_reports[$];

  // Model state: the frames awaiting an ack in insertion order, plus the two
  // configuration registers as the block should currently hold them.
  marq_pkg::entry_t held_frames[$];
  logic [marq_pkg::RetryW-1:0] retry_budget;
  logic [marq_pkg::ExpiryW-1:0] ack_wait;

  logic in_taken = 1'b0;
  logic idling_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  marq_pkg::out_item_t oldest_report;

  function automatic marq_pkg::out_item_t report_for(input logic [marq_pkg::ActionW-1:0] act,
                                                     input marq_pkg::entry_t e);
    marq_pkg::out_item_t r;
    r.action = act;
    r.out_handle = e.handle;
    r.out_seq = e.seq;
    r.out_buffer = e.buffer;
    r.last = 1'b0;
    return r;
  endfunction

  // Applies one accepted command word to the model table and queues every
  // result word it causes; the final one of the batch carries last.
  task automatic predict_outcomes(input marq_pkg::in_item_t w);
    marq_pkg::out_item_t batch[$];
    marq_pkg::out_item_t r;
    marq_pkg::entry_t e;
    int i;
    int found;
    e.seq = w.seq_number;
    e.handle = w.frame_handle;
    e.buffer = w.buffer_id;
    e.retries = retry_budget;
    e.expiry = ack_wait;
    case (w.kind)
      marq_pkg::KIND_ADD: begin
        // A full table refuses the frame and hands its buffer straight back.
        if (held_frames.size() < TableDepth) held_frames.push_back(e);
        else batch.push_back(report_for(marq_pkg::ACT_DROPPED, e));
      end
      marq_pkg::KIND_ACK, marq_pkg::KIND_REMOVE: begin
        // Only the oldest frame with this sequence number is affected.
        found = -1;
        for (i = 0; i < held_frames.size(); i++)
          if (found < 0 && held_frames[i].seq == w.seq_number) found = i;
        if (found >= 0) begin
          batch.push_back(report_for(w.kind == marq_pkg::KIND_ACK ? marq_pkg::ACT_SUCCESS
                                                                  : marq_pkg::ACT_RELEASED,
                                     held_frames[found]));
          held_frames.delete(found);
        end
      end
      marq_pkg::KIND_TICK: begin
        // After a frame is freed the walk resumes at the frame that moved into its slot.
        i = 0;
        while (i < held_frames.size()) begin
          e = held_frames[i];
          if (e.expiry == '0) begin
            if (e.retries != '0) e.retries = e.retries - 1'b1;
            if (e.retries != '0) begin
              e.expiry = ack_wait;
              held_frames[i] = e;
              batch.push_back(report_for(marq_pkg::ACT_RETX, e));
              i++;
            end else begin
              batch.push_back(report_for(marq_pkg::ACT_NOACK, e));
              held_frames.delete(i);
            end
          end else begin
            e.expiry = e.expiry - 1'b1;
            held_frames[i] = e;
            i++;
          end
        end
      end
      marq_pkg::KIND_CLEAR: begin
        // Released newest first.
        while (held_frames.size() > 0) begin
          batch.push_back(report_for(marq_pkg::ACT_RELEASED,
                                     held_frames[held_frames.size() - 1]));
          void'(held_frames.pop_back());
        end
      end
      default: begin
        // Spare kinds are ignored by the block.
      end
    endcase
    for (i = 0; i < batch.size(); i++) begin
      r = batch[i];
      r.last = (i == batch.size() - 1);
      expected_reports.push_back(r);
    end
  endtask

  function automatic marq_pkg::in_item_t command(input logic [marq_pkg::KindW-1:0] kind,
                                                 input logic [marq_pkg::SeqW-1:0] seq,
                                                 input logic [marq_pkg::HandleW-1:0] handle,
                                                 input logic [marq_pkg::BufferW-1:0] buffer);
    marq_pkg::in_item_t w;
    w.kind = kind;
    w.seq_number = seq;
    w.frame_handle = handle;
    w.buffer_id = buffer;
    return w;
  endfunction

  // Mostly well-formed traffic: sequence numbers come from a small pool so that acks
  // and removes usually find their frame, with some full-range numbers mixed in.
  function automatic marq_pkg::in_item_t random_command();
    marq_pkg::in_item_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.seq_number = ($urandom_range(0, 3) == 0) ? marq_pkg::SeqW'($urandom)
                                               : marq_pkg::SeqW'($urandom_range(0, 11));
    w.frame_handle = marq_pkg::HandleW'($urandom);
    w.buffer_id = marq_pkg::BufferW'($urandom);
    if (pick < 36) w.kind = marq_pkg::KIND_ADD;
    else if (pick < 56) w.kind = marq_pkg::KIND_ACK;
    else if (pick < 64) w.kind = marq_pkg::KIND_REMOVE;
    else if (pick < 89) w.kind = marq_pkg::KIND_TICK;
    else if (pick < 95) w.kind = marq_pkg::KIND_CLEAR;
    else w.kind = marq_pkg::KindW'($urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI)));
    return w;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_commands.push_back(random_command());
  endtask

  // Returns once every queued command has been taken and every expected word has
  // arrived, then lets a command that yields nothing finish its walk.
  task automatic wait_for_drain();
    while (pending_commands.size() != 0 || expected_reports.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Only called while the block is idle, so the model may take the new value at once.
  task automatic write_register(input logic [marq_pkg::CfgIdxW-1:0] idx,
                                input logic [marq_pkg::CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == marq_pkg::CFG_MAX_RETRIES) retry_budget = value[marq_pkg::RetryW-1:0];
    else ack_wait = value;
  endtask

  // Command driver. A word on offer stays put until the block takes it; between
  // words the sender may pause for a random burst while idling is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !in_taken) begin
      // Still waiting for ready on the current word.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      cmd_ch.valid <= 1'b0;
    end else if (pending_commands.size() == 0) begin
      cmd_ch.valid <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      send_gap <= $urandom_range(0, 3);
      cmd_ch.valid <= 1'b0;
    end else begin
      cmd_ch.valid <= 1'b1;
      cmd_ch.data <= pending_commands[0];
    end
  end

  // Result receiver: ready drops in random bursts while idling is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      rpt_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rpt_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= 1'b1;
    end
  end

  // Monitor. Accepted commands feed the model; each accepted result word is
  // compared field by field with the oldest word the model expects.
  always @(posedge clk) begin
    in_taken <= rst_n && cmd_ch.valid && cmd_ch.ready;
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      predict_outcomes(cmd_ch.data);
      void'(pending_commands.pop_front());
    end
    if (rst_n && rpt_ch.valid && rpt_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result word: action %0d seq %0d handle %0d buffer %0d",
               rpt_ch.data.action, rpt_ch.data.out_seq, rpt_ch.data.out_handle,
               rpt_ch.data.out_buffer);
        error_count++;
      end else begin
        oldest_report = expected_reports.pop_front();
        if (rpt_ch.data.action !== oldest_report.action) begin
          $error("action: expected %0d, actual %0d", oldest_report.action, rpt_ch.data.action);
          error_count++;
        end
        if (rpt_ch.data.out_handle !== oldest_report.out_handle) begin
          $error("out_handle: expected %0d, actual %0d", oldest_report.out_handle,
                 rpt_ch.data.out_handle);
          error_count++;
        end
        if (rpt_ch.data.out_seq !== oldest_report.out_seq) begin
          $error("out_seq: expected %0d, actual %0d", oldest_report.out_seq,
                 rpt_ch.data.out_seq);
          error_count++;
        end
        if (rpt_ch.data.out_buffer !== oldest_report.out_buffer) begin
          $error("out_buffer: expected %0d, actual %0d", oldest_report.out_buffer,
                 rpt_ch.data.out_buffer);
          error_count++;
        end
        if (rpt_ch.data.last !== oldest_report.last) begin
          $error("last: expected %0d, actual %0d", oldest_report.last, rpt_ch.data.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing result word stops the run here.
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("mac_ack_retry_queue_core_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    rpt_ch.ready = 1'b0;
    retry_budget = marq_pkg::MaxRetriesReset;
    ack_wait = marq_pkg::AckWaitReset;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset defaults of three retries and two ticks.
    // Commands against an empty table, then the spare kinds, which must be ignored.
    pending_commands.push_back(command(marq_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 8'hFF));
    pending_commands.push_back(command(marq_pkg::KIND_ACK, 8'h10, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_REMOVE, 8'h10, 8'hFF, 8'hFF));
    pending_commands.push_back(command(KIND_SPARE_LO, 8'hFF, 8'hFF, 8'hFF));
    pending_commands.push_back(command(KIND_SPARE_LO + 3'd1, 8'h5A, 8'hA5, 8'h3C));
    pending_commands.push_back(command(KIND_SPARE_HI, 8'h00, 8'h00, 8'h00));
    // Fill the table, with field extremes and a duplicated sequence number; the
    // ninth add finds it full and is dropped.
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h00, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'hFF, 8'hFF, 8'hFF));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h05, 8'h01, 8'h02));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h05, 8'h03, 8'h04));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'hAA, 8'h55, 8'hAA));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h55, 8'hAA, 8'h55));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h07, 8'h70, 8'h71));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h08, 8'h80, 8'h81));
    pending_commands.push_back(command(marq_pkg::KIND_ADD, 8'h09, 8'h90, 8'h91));
    // The ack hits the older of the two frames numbered 5, the remove the newer,
    // and a second remove finds nothing left.
    pending_commands.push_back(command(marq_pkg::KIND_ACK, 8'h05, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_REMOVE, 8'h05, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_REMOVE, 8'h05, 8'h00, 8'h00));
    // Two ticks run the expiry down to zero; the third retransmits every frame.
    pending_commands.push_back(command(marq_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_ACK, 8'hFF, 8'h00, 8'h00));
    pending_commands.push_back(command(marq_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00));
    wait_for_drain();

    // Largest budget and longest wait: ticks only count down, so acks, removes,
    // clears and dropped adds carry this phase. A clear empties the stuck frames.
    write_register(marq_pkg::CFG_MAX_RETRIES, 8'd7);
    write_register(marq_pkg::CFG_ACK_WAIT_TICKS, 8'd255);
    queue_random(20);
    pending_commands.push_back(command(marq_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00));
    wait_for_drain();

    // Zero budget behaves like one: the first tick after an add frees it with no-ack.
    write_register(marq_pkg::CFG_MAX_RETRIES, 8'd0);
    write_register(marq_pkg::CFG_ACK_WAIT_TICKS, 8'd0);
    queue_random(22);
    wait_for_drain();

    // Many retransmits before a frame gives up.
    write_register(marq_pkg::CFG_MAX_RETRIES, 8'd7);
    write_register(marq_pkg::CFG_ACK_WAIT_TICKS, 8'd1);
    queue_random(22);
    wait_for_drain();

    // Final stretch at full rate on both channels with a random mid-range setting.
    idling_on = 1'b0;
    write_register(marq_pkg::CFG_MAX_RETRIES, marq_pkg::CfgDataW'($urandom_range(1, 6)));
    write_register(marq_pkg::CFG_ACK_WAIT_TICKS, marq_pkg::CfgDataW'($urandom_range(0, 3)));
    queue_random(30);
    wait_for_drain();

    if (error_count == 0) begin
      $display("mac_ack_retry_queue_core_test: PASS");
    end else begin
      $display("mac_ack_retry_queue_core_test: FAIL");
    end
    $finish;
  end

endmodule

[mac_ack_retry_queue_core.f]
sv/marq_pkg.sv
sv/marq_stream_if.sv
sv/marq_table.sv
sv/marq_ctrl.sv
sv/mac_ack_retry_queue_core.sv
test/mac_ack_retry_queue_core_test.sv
